// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL of the cross descriptor distance core.
// Each macro names the clock i_clk and the active-low reset i_rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that holds at every clock edge outside reset.
`define GCDD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// A condition that, once seen, is followed by a property in the next cycle.
`define GCDD_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error(msg);

`endif

// ----- design/gcdd_pkg.sv -----
// ---------------------------------------------------------------------------
// gcdd_pkg
// Types and fixed widths shared by the cross descriptor distance core.
// ---------------------------------------------------------------------------
`default_nettype none

package gcdd_pkg;

    localparam int GRAD_W    = 16;
    localparam int PROD_W    = 2 * GRAD_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int DIST_W    = 43;
    localparam int OUT_CNT_W = 11;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_STORE,
        S_DIV_LOAD,
        S_DIV,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic div_load;
        logic div_step;
        logic scan_start;
        logic scan_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic scan_done;
    } t_stat;

endpackage

`default_nettype wire

// ----- design/gcdd_ram.sv -----
// ---------------------------------------------------------------------------
// gcdd_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module gcdd_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/gcdd_datapath.sv -----
// ---------------------------------------------------------------------------
// gcdd_datapath
// Cross product pipeline, cell store, running sum, bit-serial mean divider,
// L1 scan over the stored cells and the registered result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gcdd_datapath
    import gcdd_pkg::*;
#(
    parameter int MAX_CELLS = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire logic signed [GRAD_W-1:0] i_a_grad_u,
    input  wire logic signed [GRAD_W-1:0] i_a_grad_v,
    input  wire logic signed [GRAD_W-1:0] i_b_grad_u,
    input  wire logic signed [GRAD_W-1:0] i_b_grad_v,
    input  wire t_cmd                     i_cmd,
    output t_stat                         o_stat,
    output logic                          o_valid,
    output logic [DIST_W-1:0]             o_distance,
    output logic [OUT_CNT_W-1:0]          o_cell_count,
    output logic                          o_overflowed
);

    localparam int CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int ADDR_W    = $clog2(MAX_CELLS);
    localparam int SUM_W     = CROSS_W + $clog2(MAX_CELLS);
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);
    localparam int ABS_W     = CROSS_W + 1;

    logic signed [PROD_W-1:0]  r_p1;
    logic signed [PROD_W-1:0]  r_p2;
    logic                      r_s1_vld;
    logic signed [CROSS_W-1:0] cross_prod;
    logic                      wr_en;

    logic signed [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]          r_count;
    logic                      r_dropped;

    logic [SUM_W-1:0]          sum_mag;
    logic [SUM_W-1:0]          r_quo;
    logic [CNT_W-1:0]          r_rem;
    logic                      r_neg;
    logic [DIV_CNT_W-1:0]      r_div_cnt;
    logic [CNT_W:0]            rem_sh;
    logic [CNT_W:0]            rem_diff;
    logic [CROSS_W-1:0]        mean_mag;
    logic signed [CROSS_W-1:0] r_mean;

    logic [CNT_W-1:0]          r_scan_addr;
    logic                      rd_en;
    logic                      r_rd_vld;
    logic signed [CROSS_W-1:0] rd_data;
    logic signed [ABS_W-1:0]   diff;
    logic [ABS_W-1:0]          r_abs;
    logic                      r_abs_vld;
    logic [DIST_W:0]           acc_sum;
    logic [DIST_W-1:0]         r_acc;

    // Stage one: the two products of the cross product.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_p1 <= i_a_grad_u * i_b_grad_v;
            r_p2 <= i_a_grad_v * i_b_grad_u;
        end
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_accept;
        end
    end

    assign cross_prod = CROSS_W'(r_p1) - CROSS_W'(r_p2);
    assign wr_en = r_s1_vld && (r_count < CNT_W'(MAX_CELLS));

    // Stage two: store the cell, add it to the sum, or note the drop; emit clears the pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.emit) begin
            r_sum     <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (wr_en) begin
            r_sum   <= r_sum + SUM_W'(cross_prod);
            r_count <= r_count + 1'b1;
        end else if (r_s1_vld) begin
            r_dropped <= 1'b1;
        end
    end

    // Restoring divider on the magnitude of the sum, one quotient bit a cycle.
    assign sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_count};
    assign mean_mag = r_quo[CROSS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_quo <= sum_mag;
            r_rem <= '0;
            r_neg <= r_sum[SUM_W-1];
        end else if (i_cmd.div_step && (r_div_cnt != '0)) begin
            r_quo <= {r_quo[SUM_W-2:0], !rem_diff[CNT_W]};
            r_rem <= rem_diff[CNT_W] ? rem_sh[CNT_W-1:0] : rem_diff[CNT_W-1:0];
        end
        r_mean <= r_neg ? -$signed(mean_mag) : $signed(mean_mag);
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_load) begin
            r_div_cnt <= DIV_CNT_W'(SUM_W);
        end else if (i_cmd.div_step && (r_div_cnt != '0)) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    gcdd_ram #(
        .WIDTH (CROSS_W),
        .DEPTH (MAX_CELLS)
    ) u_cross_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (cross_prod),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_scan_addr[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    // L1 scan: read, subtract the mean and take the magnitude, accumulate.
    assign rd_en   = i_cmd.scan_step && (r_scan_addr != r_count);
    assign diff    = ABS_W'(rd_data) - ABS_W'(r_mean);
    assign acc_sum = {1'b0, r_acc} + (DIST_W + 1)'(r_abs);

    always_ff @(posedge i_clk) begin
        r_abs <= diff[ABS_W-1] ? ABS_W'(-diff) : ABS_W'(diff);
        if (i_cmd.scan_start) begin
            r_scan_addr <= '0;
            r_acc       <= '0;
        end else begin
            if (rd_en) begin
                r_scan_addr <= r_scan_addr + 1'b1;
            end
            if (r_abs_vld) begin
                r_acc <= acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];
            end
        end
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_abs_vld <= 1'b0;
        end else begin
            r_rd_vld  <= rd_en;
            r_abs_vld <= r_rd_vld;
        end
    end

    assign o_stat.div_done  = (r_div_cnt == '0);
    assign o_stat.scan_done = (r_scan_addr == r_count) && !r_rd_vld && !r_abs_vld;

    // Result register: the strobe lasts exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_distance   <= r_acc;
            o_cell_count <= OUT_CNT_W'(r_count);
            o_overflowed <= r_dropped;
        end
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
    end

    `GCDD_ASSERT(a_count_in_range, r_count <= CNT_W'(MAX_CELLS),
        "cell count beyond capacity")
    `GCDD_ASSERT(a_no_store_when_full, !(wr_en && r_count == CNT_W'(MAX_CELLS)),
        "store written at full capacity")
    `GCDD_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid,
        "result strobe held for more than one cycle")

endmodule

`default_nettype wire

// ----- design/gcdd_ctrl.sv -----
// ---------------------------------------------------------------------------
// gcdd_ctrl
// Sequencer: accumulates cells, then runs the mean division, the L1 scan
// and the result beat.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gcdd_ctrl
    import gcdd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_accept_last,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_accept_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE:    n_state = S_DIV_LOAD;
            S_DIV_LOAD: n_state = S_DIV;
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE:  o_busy = 1'b0;
            S_STORE: o_busy = 1'b1;
            S_DIV_LOAD: begin
                o_cmd.div_load   = 1'b1;
                o_cmd.scan_start = 1'b1;
            end
            S_DIV:   o_cmd.div_step  = 1'b1;
            S_SCAN:  o_cmd.scan_step = 1'b1;
            S_EMIT:  o_cmd.emit      = 1'b1;
            default: o_busy = 1'b0;
        endcase
    end

    `GCDD_ASSERT(a_emit_after_work, !o_cmd.emit || (i_stat.div_done && i_stat.scan_done),
        "result emitted before division and scan finished")
    `GCDD_ASSERT(a_idle_no_work, o_busy || (o_cmd == '0),
        "work command issued while idle")
    `GCDD_ASSERT_NEXT(a_last_makes_busy, i_accept_last, o_busy,
        "not busy after the last cell")

endmodule

`default_nettype wire

// ----- design/gradient_cross_descriptor_distance_core.sv -----
// ---------------------------------------------------------------------------
// gradient_cross_descriptor_distance_core
// L1 distance of the mean-removed cross products of two gradient descriptors.
//
// Input: one cell is taken at each rising edge where start is high and busy
// is low. While a pair accumulates, busy stays low and a cell may be given
// every cycle. The cell with i_last_cell set closes the pair and raises busy.
// Cells beyond MAX_CELLS are dropped and reported through o_overflowed.
// Output: one beat per pair, o_valid high for a single cycle with
// o_distance, o_cell_count and o_overflowed. The receiver cannot stall.
// After the last cell, the bit-serial mean divider produces one quotient bit
// per step over SUM_W = 33 + clog2(MAX_CELLS) bits (43 by default), then
// the L1 scan reads the N stored cells from the cell store one entry a
// cycle. busy falls in the cycle that shows o_valid.
// Reset (i_rst_n low, synchronous) empties the pair and returns to idle; the
// cell store needs no clearing since only entries of the current pair are read.
// ---------------------------------------------------------------------------
`default_nettype none

module gradient_cross_descriptor_distance_core
    import gcdd_pkg::*;
#(
    parameter int MAX_CELLS = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [GRAD_W-1:0] i_a_grad_u,
    input  wire logic signed [GRAD_W-1:0] i_a_grad_v,
    input  wire logic signed [GRAD_W-1:0] i_b_grad_u,
    input  wire logic signed [GRAD_W-1:0] i_b_grad_v,
    input  wire logic                     i_last_cell,
    output logic                          o_valid,
    output logic [DIST_W-1:0]             o_distance,
    output logic [OUT_CNT_W-1:0]          o_cell_count,
    output logic                          o_overflowed
);

    logic  accept;
    t_cmd  cmd;
    t_stat stat;

    assign accept = start && !busy;

    gcdd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept_last (accept && i_last_cell),
        .i_stat        (stat),
        .o_cmd         (cmd),
        .o_busy        (busy)
    );

    gcdd_datapath #(
        .MAX_CELLS (MAX_CELLS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_a_grad_u   (i_a_grad_u),
        .i_a_grad_v   (i_a_grad_v),
        .i_b_grad_u   (i_b_grad_u),
        .i_b_grad_v   (i_b_grad_v),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_distance   (o_distance),
        .o_cell_count (o_cell_count),
        .o_overflowed (o_overflowed)
    );

endmodule

`default_nettype wire
